// ===== rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int YEAR_W = 16;
    localparam int REV_W  = 48;
    localparam int TAG_W  = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from byte address bit 2
    localparam logic REG_SORT_KEY = 1'b0;

    // sort key codes
    localparam logic KEY_YEAR    = 1'b0;
    localparam logic KEY_REVENUE = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [YEAR_W-1:0]        year;
        logic signed [REV_W-1:0]  revenue;
        logic [TAG_W-1:0]         tag;
    } t_rec;

    typedef struct packed {
        logic load;      // an item is accepted this cycle
        logic sort;      // compare-exchange phase active
        logic parity;    // which pairs exchange this phase
        logic shift;     // result taken, chain moves towards the head
        logic sort_key;
    } t_cell_ctrl;

    // true when a sorts strictly below b under the chosen key
    function automatic logic key_less(input t_rec a, input t_rec b, input logic key);
        logic less;
        begin
            if (key == KEY_REVENUE) begin
                less = (a.revenue < b.revenue);
            end else begin
                less = (a.year < b.year);
            end
            key_less = less;
        end
    endfunction

endpackage

// ===== rtl/rsd_cell.sv =====
`timescale 1ns / 1ps

module rsd_cell
    import rsd_pkg::*;
#(
    parameter bit ODD_POS = 1'b0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_rec       i_load_rec,
    input  logic       i_left_valid,
    input  t_rec       i_left_rec,
    input  logic       i_left_swap,
    input  logic       i_right_valid,
    input  t_rec       i_right_rec,
    output logic       o_valid,
    output t_rec       o_rec,
    output logic       o_swap
);

    logic r_valid;
    logic n_valid;
    t_rec r_rec;
    t_rec n_rec;
    logic w_is_left;

    // left member of a pair when own position parity matches the phase
    assign w_is_left = (i_ctrl.parity == ODD_POS);

    assign o_swap = i_ctrl.sort && w_is_left && r_valid && i_right_valid &&
                    key_less(r_rec, i_right_rec, i_ctrl.sort_key);

    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctrl.load) begin
            // first empty cell takes the item
            if (!r_valid && i_left_valid) begin
                n_valid = 1'b1;
                n_rec   = i_load_rec;
            end
        end else if (i_ctrl.sort) begin
            if (o_swap) begin
                n_rec = i_right_rec;
            end else if (!w_is_left && i_left_swap) begin
                n_rec = i_left_rec;
            end
        end else if (i_ctrl.shift) begin
            n_valid = i_right_valid;
            n_rec   = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

// ===== rtl/record_sort_descending_core.sv =====
`timescale 1ns / 1ps
// loading: one item per cycle, a final item starts the sort in the next cycle
// sorting: odd-even compare-exchange along the cell chain, pair parity alternating by phase
// results leave the head largest first, one result per cycle while i_ready is high
// no new set is taken until the last result of the current one has been taken
// synchronous active-low reset empties the chain, clears overflow and sort_key

module record_sort_descending_core
    import rsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // item input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [YEAR_W-1:0]       i_year,
    input  logic signed [REV_W-1:0] i_revenue,
    input  logic [TAG_W-1:0]        i_record_tag,
    input  logic                    i_final_item,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [YEAR_W-1:0]       o_out_year,
    output logic signed [REV_W-1:0] o_out_revenue,
    output logic [TAG_W-1:0]        o_out_tag,
    output logic                    o_end_of_run,
    output logic                    o_overflowed,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int CNT_W = $clog2(DEPTH);

    // fsm and control registers
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_sort_cnt;
    logic [CNT_W-1:0]  n_sort_cnt;
    logic              r_dropped;
    logic              n_dropped;
    logic              r_sort_key;

    // chain wiring
    t_cell_ctrl        w_ctrl;
    t_rec              w_load_rec;
    t_rec              w_rec   [DEPTH];
    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_swap;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_cfg_wr;
    logic              w_sort_done;

    // ------------------------------------------------------------------
    // configuration register, written in the apb access phase
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key <= KEY_YEAR;
        end else if (w_cfg_wr && (paddr[2] == REG_SORT_KEY)) begin
            r_sort_key <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SORT_KEY) begin
            prdata[0] = r_sort_key;
        end
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_acc   = o_valid && i_ready;
    assign w_sort_done = (r_sort_cnt == CNT_W'(DEPTH - 1));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_sort_cnt = r_sort_cnt;
        n_dropped  = r_dropped;
        case (r_state)
            ST_LOAD: begin
                n_sort_cnt = '0;
                // a full chain drops the item, the final one included
                if (w_in_acc && w_valid[DEPTH-1]) begin
                    n_dropped = 1'b1;
                end
                if (w_in_acc && i_final_item) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                n_sort_cnt = r_sort_cnt + 1'b1;
                if (w_sort_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // the run ends when the last stored record is taken
                if (w_out_acc && !w_valid[1]) begin
                    n_state   = ST_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_sort_cnt <= '0;
            r_dropped  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sort_cnt <= n_sort_cnt;
            r_dropped  <= n_dropped;
        end
    end

    // ------------------------------------------------------------------
    // outputs and chain control
    // ------------------------------------------------------------------
    always_comb begin
        o_ready         = 1'b0;
        o_valid         = 1'b0;
        w_ctrl.load     = 1'b0;
        w_ctrl.sort     = 1'b0;
        w_ctrl.parity   = r_sort_cnt[0];
        w_ctrl.shift    = 1'b0;
        w_ctrl.sort_key = r_sort_key;
        case (r_state)
            ST_LOAD: begin
                o_ready     = 1'b1;
                w_ctrl.load = i_valid;
            end
            ST_SORT: begin
                w_ctrl.sort = 1'b1;
            end
            ST_EMIT: begin
                // head cell holds the largest remaining record
                o_valid      = w_valid[0];
                w_ctrl.shift = w_valid[0] && i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_load_rec.year    = i_year;
    assign w_load_rec.revenue = i_revenue;
    assign w_load_rec.tag     = i_record_tag;

    assign o_out_year    = w_rec[0].year;
    assign o_out_revenue = w_rec[0].revenue;
    assign o_out_tag     = w_rec[0].tag;
    assign o_end_of_run  = !w_valid[1];
    assign o_overflowed  = r_dropped;

    // ------------------------------------------------------------------
    // cell chain: records fill from the head in arrival order, odd-even
    // exchange on strict less-than keeps equal keys in arrival order
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic w_left_valid;
        t_rec w_left_rec;
        logic w_left_swap;
        logic w_right_valid;
        t_rec w_right_rec;

        if (g == 0) begin : g_head
            assign w_left_valid = 1'b1;
            assign w_left_rec   = '0;
            assign w_left_swap  = 1'b0;
        end else begin : g_mid
            assign w_left_valid = w_valid[g-1];
            assign w_left_rec   = w_rec[g-1];
            assign w_left_swap  = w_swap[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_valid = 1'b0;
            assign w_right_rec   = '0;
        end else begin : g_inner
            assign w_right_valid = w_valid[g+1];
            assign w_right_rec   = w_rec[g+1];
        end

        rsd_cell #(
            .ODD_POS (1'(g % 2))
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_load_rec    (w_load_rec),
            .i_left_valid  (w_left_valid),
            .i_left_rec    (w_left_rec),
            .i_left_swap   (w_left_swap),
            .i_right_valid (w_right_valid),
            .i_right_rec   (w_right_rec),
            .o_valid       (w_valid[g]),
            .o_rec         (w_rec[g]),
            .o_swap        (w_swap[g])
        );
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("gap in occupied cells");

    // an emitting run never finds the head cell empty
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_valid[0])
        else $error("emit phase with empty chain");

    // a final item always starts the sort
    a_final_sorts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_final_item) |=> (r_state == ST_SORT))
        else $error("final item did not start the sort");

    // taking the last result leaves an empty chain and a clear overflow flag
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_end_of_run) |=> (r_state == ST_LOAD && w_valid == '0 && !r_dropped))
        else $error("chain not empty after end of run");

endmodule
